// ===== hw/rtl/binary_to_decimal_ascii_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decimal ASCII converter.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B2D_ASSERT_IMPLY(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("b2d: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define B2D_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("b2d: next-cycle implication failed");

`endif

// ===== hw/rtl/b2d_pkg.sv =====
// ----------------------------------------------------------------------------
// b2d_pkg
// Types, constants and a helper function of the decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int VALUE_W            = 64;
    localparam int CHAR_W             = 7;
    localparam int BIT_CNT_W          = $clog2(VALUE_W);
    localparam int DEFAULT_MAX_DIGITS = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;

    typedef struct packed {
        logic [VALUE_W-1:0] value_bits;
        logic               signed_mode;
    } b2d_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic              too_long;
    } b2d_out_t;

    // A classified job as it waits between the front and back parts.
    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               err;
    } b2d_job_t;

    function automatic logic [VALUE_W-1:0] pow10(input int n);
        logic [VALUE_W-1:0] p;
        p = VALUE_W'(1);
        for (int i = 0; i < n; i++)
        begin
            p = p * VALUE_W'(10);
        end
        return p;
    endfunction

endpackage

// ===== hw/rtl/b2d_front.sv =====
// ----------------------------------------------------------------------------
// b2d_front
// Accepts a value, takes its magnitude and checks it against the digit limit.
// ----------------------------------------------------------------------------
module b2d_front
    import b2d_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  b2d_in_t  operand,
    output logic     push,
    output b2d_job_t push_data,
    input  logic     full
);

    localparam logic [VALUE_W-1:0] LIMIT     = pow10(MAX_DIGITS);
    // A negative value's magnitude reaches the limit exactly when the raw
    // value is at or below two's complement of the limit.
    localparam logic [VALUE_W-1:0] NEG_BOUND = ~LIMIT + VALUE_W'(1);

    logic    hold_valid_reg;
    logic    hold_valid_next;
    b2d_in_t hold_reg;
    logic    accept;
    logic    neg;

    assign push   = hold_valid_reg && !full;
    assign busy   = hold_valid_reg && full;
    assign accept = start && !busy;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= operand;
        end
    end

    assign neg = hold_reg.signed_mode && hold_reg.value_bits[VALUE_W-1];

    always_comb
    begin
        push_data.neg = neg;
        push_data.mag = neg ? (~hold_reg.value_bits + VALUE_W'(1)) : hold_reg.value_bits;
        push_data.err = neg ? (hold_reg.value_bits <= NEG_BOUND)
                            : (hold_reg.value_bits >= LIMIT);
    end

endmodule

// ===== hw/rtl/b2d_queue.sv =====
// ----------------------------------------------------------------------------
// b2d_queue
// Short job queue between the classifying front and the converting back.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_macros.svh"

module b2d_queue
    import b2d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  b2d_job_t push_data,
    output logic     full,
    input  logic     pop,
    output b2d_job_t pop_data,
    output logic     empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    b2d_job_t             job_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = job_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_mem[wr_ptr_reg] <= push_data;
        end
    end

    `B2D_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, push, !full)
    `B2D_ASSERT_IMPLY(a_no_pop_when_empty, clk, rst_n, pop, !empty)
    `B2D_ASSERT_NEXT(a_count_tracks_push, clk, rst_n, push && !pop, count_reg != '0)

endmodule

// ===== hw/rtl/b2d_back.sv =====
// ----------------------------------------------------------------------------
// b2d_back
// Bit-serial double-dabble conversion and one-character-per-cycle output.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_macros.svh"

module b2d_back
    import b2d_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     empty,
    output logic     pop,
    input  b2d_job_t pop_data,
    output logic     result_valid,
    output b2d_out_t result
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DABBLE = 4'b0010,
        ST_SIGN   = 4'b0100,
        ST_EMIT   = 4'b1000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]     digit_idx_reg, digit_idx_next;
    logic                 started_reg, started_next;
    logic                 neg_reg, neg_next;
    logic [VALUE_W-1:0]   shift_reg, shift_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_digit;
    b2d_out_t             result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;
    logic                 error_out;
    logic                 error_shaped;
    logic                 text_out;
    logic                 text_shaped;
    logic                 minus_out;

    assign pop          = (state_reg == ST_IDLE) && !empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign top_digit    = bcd_reg[BCD_W-1 -: 4];

    // Add three to every digit of five or more before each shift.
    always_comb
    begin
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ? bcd_reg[4*d +: 4] + 4'd3
                                                             : bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        bit_cnt_next      = bit_cnt_reg;
        digit_idx_next    = digit_idx_reg;
        started_next      = started_reg;
        neg_next          = neg_reg;
        shift_next        = shift_reg;
        bcd_next          = bcd_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    if (pop_data.err)
                    begin
                        result_valid_next     = 1'b1;
                        result_next.char_code = CHAR_NONE;
                        result_next.last_char = 1'b1;
                        result_next.too_long  = 1'b1;
                    end
                    else
                    begin
                        shift_next   = pop_data.mag;
                        neg_next     = pop_data.neg;
                        bcd_next     = '0;
                        bit_cnt_next = '0;
                        state_next   = ST_DABBLE;
                    end
                end
            end
            ST_DABBLE:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
                shift_next   = shift_reg << 1;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == '1)
                begin
                    digit_idx_next = IDX_W'(MAX_DIGITS - 1);
                    started_next   = 1'b0;
                    state_next     = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                result_valid_next     = 1'b1;
                result_next.char_code = ASCII_MINUS;
                result_next.last_char = 1'b0;
                result_next.too_long  = 1'b0;
                state_next            = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Leading zeros are skipped, but the units digit always goes out.
                if ((top_digit != 4'd0) || started_reg || (digit_idx_reg == '0))
                begin
                    result_valid_next     = 1'b1;
                    result_next.char_code = ASCII_ZERO + CHAR_W'(top_digit);
                    result_next.last_char = (digit_idx_reg == '0);
                    result_next.too_long  = 1'b0;
                    started_next          = 1'b1;
                end
                bcd_next       = bcd_reg << 4;
                digit_idx_next = digit_idx_reg - IDX_W'(1);
                if (digit_idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg   <= bit_cnt_next;
        digit_idx_reg <= digit_idx_next;
        started_reg   <= started_next;
        neg_reg       <= neg_next;
        shift_reg     <= shift_next;
        bcd_reg       <= bcd_next;
        result_reg    <= result_next;
    end

    assign error_out    = result_valid_reg && result_reg.too_long;
    assign error_shaped = result_reg.last_char && (result_reg.char_code == CHAR_NONE);
    assign text_out     = result_valid_reg && !result_reg.too_long;
    assign text_shaped  = (result_reg.char_code == ASCII_MINUS)
                       || ((result_reg.char_code >= ASCII_ZERO)
                           && (result_reg.char_code <= ASCII_NINE));
    assign minus_out    = result_valid_reg && (result_reg.char_code == ASCII_MINUS)
                       && !result_reg.last_char;

    `B2D_ASSERT_IMPLY(a_error_is_single, clk, rst_n, error_out, error_shaped)
    `B2D_ASSERT_IMPLY(a_char_is_text, clk, rst_n, text_out, text_shaped)
    `B2D_ASSERT_NEXT(a_sign_emits_minus, clk, rst_n, state_reg == ST_SIGN, minus_out)

endmodule

// ===== hw/rtl/binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts a 64-bit signed or unsigned value into decimal ASCII characters.
// ----------------------------------------------------------------------------
// Usage: drive operand and raise start; the transaction is taken at a clock
// edge where start is high and busy is low. busy rises only while a value
// waits in the input stage and the job queue is full.
// Results come out one character per transaction on result, each valid for
// exactly one cycle while result_valid is high: an optional '-', then the
// digits, most significant first, without leading zeros. last_char marks the
// final character. A magnitude of 10^MAX_DIGITS or more gives one transaction
// with too_long and last_char set and char_code zero.
// Flow: a value passes the input register and the job queue; the back end
// then runs a bit-serial double-dabble pass over all 64 bits, sends a minus
// sign for a negative value and scans MAX_DIGITS digits; each skipped leading
// zero delays the first digit. The back end takes the next job only once it
// is idle again; an error job leaves it idle, and its transaction passes the
// input register, the queue and the result register. Reset empties the queue
// and drops any conversion. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core
    import b2d_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  b2d_in_t  operand,
    output logic     result_valid,
    output b2d_out_t result
);

    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    b2d_job_t push_data;
    b2d_job_t pop_data;

    b2d_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand   (operand),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    b2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    b2d_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop          (pop),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
